// ----- src/bsa_pkg.sv -----
// Shared types, codes and helper functions of the bitmap slot allocator.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package bsa_pkg;

  // Width of one bitmap word and of the bit position inside it.
  localparam int MAP_WORD_BITS = 64;
  localparam int BIT_SEL_W     = 6;

  // Fixed field widths of the channels and of the configuration port.
  localparam int KIND_W    = 2;
  localparam int SLOT_W    = 10;
  localparam int STATUS_W  = 2;
  localparam int USED_OUT_W = 11;
  localparam int HANDLE_W  = 64;
  localparam int STRIDE_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;

  // Request kinds; the unused code behaves as a lookup.
  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DBL_FREE  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VISIBLE    = 2'd3;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd32;

  // Configuration registers as one bundle.
  typedef struct packed {
    logic [HANDLE_W-1:0] cpu_base;
    logic [HANDLE_W-1:0] gpu_base;
    logic [STRIDE_W-1:0] slot_stride;
    logic                shader_visible;
  } cfg_regs_t;

  // Position of the lowest set bit of a nonzero word. The word is split in
  // eight bytes: the lowest nonzero byte is picked first, then the lowest bit
  // inside it, so the logic stays two small priority encoders deep.
  function automatic logic [BIT_SEL_W-1:0] lowest_set(input map_word_t w);
    logic [7:0] grp_any;
    logic [2:0] grp;
    logic [7:0] byte_v;
    logic [2:0] pos;
    for (int i = 0; i < 8; i++) begin
      grp_any[i] = |w[i*8 +: 8];
    end
    grp = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (grp_any[i]) begin
        grp = 3'(i);
      end
    end
    byte_v = w[{grp, 3'b000} +: 8];
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (byte_v[i]) begin
        pos = 3'(i);
      end
    end
    return {grp, pos};
  endfunction

endpackage

`default_nettype wire

// ----- src/bsa_if.sv -----
// Valid/ready channel interfaces for requests and results of the allocator.
// Depends on bsa_pkg for the field widths.
`default_nettype none

interface bsa_in_if;
  logic                         valid;
  logic                         ready;
  logic [bsa_pkg::KIND_W-1:0]   kind;
  logic [bsa_pkg::SLOT_W-1:0]   slot_index;

  modport source (output valid, output kind, output slot_index, input ready);
  modport sink   (input valid, input kind, input slot_index, output ready);
endinterface

interface bsa_out_if;
  logic                           valid;
  logic                           ready;
  logic [bsa_pkg::STATUS_W-1:0]   status;
  logic [bsa_pkg::SLOT_W-1:0]     result_index;
  logic [bsa_pkg::HANDLE_W-1:0]   cpu_handle;
  logic [bsa_pkg::HANDLE_W-1:0]   gpu_handle;
  logic                           gpu_valid;
  logic [bsa_pkg::USED_OUT_W-1:0] used_count;

  modport source (output valid, output status, output result_index, output cpu_handle,
                  output gpu_handle, output gpu_valid, output used_count, input ready);
  modport sink   (input valid, input status, input result_index, input cpu_handle,
                  input gpu_handle, input gpu_valid, input used_count, output ready);
endinterface

`default_nettype wire

// ----- src/bsa_map_mem.sv -----
// Free bitmap storage: one write port and one read port with registered data.
// Depends on bsa_pkg for the bitmap word type.
`default_nettype none

module bsa_map_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic               clk,
  input  wire logic               rd_en,
  input  wire logic [AW-1:0]      rd_addr,
  output bsa_pkg::map_word_t      rd_data,
  input  wire logic               wr_en,
  input  wire logic [AW-1:0]      wr_addr,
  input  bsa_pkg::map_word_t      wr_data
);

  bsa_pkg::map_word_t mem_r [DEPTH];
  bsa_pkg::map_word_t rd_data_r;

  // Synchronous write and read; the read data is registered and appears in the cycle after the read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- src/bsa_handle_unit.sv -----
// Handle arithmetic: registers index times stride, then adds the two bases.
// Depends on bsa_pkg for the configuration bundle and handle widths.
`default_nettype none

module bsa_handle_unit #(
  parameter int IDX_W = 10
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [IDX_W-1:0]             idx,
  input  bsa_pkg::cfg_regs_t                cfg,
  output logic [bsa_pkg::HANDLE_W-1:0]      cpu_sum,
  output logic [bsa_pkg::HANDLE_W-1:0]      gpu_sum
);

  localparam int PROD_W = IDX_W + bsa_pkg::STRIDE_W;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;

  // Slot offset, registered ahead of the wide adds.
  assign prod_nxt = PROD_W'(idx) * PROD_W'(cfg.slot_stride);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  // Base plus offset, wrapping at the handle width.
  assign cpu_sum = cfg.cpu_base + bsa_pkg::HANDLE_W'(prod_r);
  assign gpu_sum = cfg.gpu_base + bsa_pkg::HANDLE_W'(prod_r);

endmodule

`default_nettype wire

// ----- src/bitmap_slot_allocator.sv -----
// Bitmap slot allocator: control sequencer, configuration registers and
// result register. Depends on bsa_pkg, bsa_if, bsa_map_mem, bsa_handle_unit.
`default_nettype none

// Allocates, frees and looks up descriptor slots held as a free bitmap of
// 64-bit words in a single-port-read, single-port-write memory. One request
// is handled at a time. An allocate scans from the hint word and reads up
// to SLOT_COUNT/64 bitmap words (16 by default); the scan reads one word per
// cycle through the memory read port. A free reads its bitmap word and
// writes it back unless the slot is already free; a lookup reads none. A
// heap that is already full answers an allocate without reading the bitmap.
// After reset a clearing pass writes every bitmap word to all ones, during
// which no request is taken; configuration writes are taken at any time but
// must only be issued while the block is idle. The result register frees the
// request side: the next request is taken while a result waits.
module bitmap_slot_allocator #(
  parameter int SLOT_COUNT = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  bsa_in_if.sink                                 in_ch,
  bsa_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [bsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bsa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int MAP_WORDS    = SLOT_COUNT / bsa_pkg::MAP_WORD_BITS;
  localparam int MAPPED_SLOTS = MAP_WORDS * bsa_pkg::MAP_WORD_BITS;
  localparam int WORD_AW      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W        = ($clog2(MAPPED_SLOTS) > bsa_pkg::SLOT_W) ?
                                $clog2(MAPPED_SLOTS) : bsa_pkg::SLOT_W;
  localparam int USED_W       = $clog2(SLOT_COUNT + 1);
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FREE   = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic [WORD_AW-1:0]             cur_w_r, cur_w_nxt;
  logic [WORD_AW-1:0]             scan_n_r, scan_n_nxt;
  logic [WORD_AW-1:0]             hint_r, hint_nxt;
  logic [USED_W-1:0]              used_r, used_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic [bsa_pkg::STATUS_W-1:0]   status_r, status_nxt;
  bsa_pkg::cfg_regs_t             cfg_r;

  logic                           out_valid_r, out_valid_nxt;
  logic [bsa_pkg::STATUS_W-1:0]   out_status_r;
  logic [bsa_pkg::SLOT_W-1:0]     out_index_r;
  logic [bsa_pkg::HANDLE_W-1:0]   out_cpu_r;
  logic [bsa_pkg::HANDLE_W-1:0]   out_gpu_r;
  logic                           out_gvalid_r;
  logic [bsa_pkg::USED_OUT_W-1:0] out_used_r;
  logic                           out_load;

  logic                           map_rd_en;
  logic [WORD_AW-1:0]             map_rd_addr;
  bsa_pkg::map_word_t             map_rd_data;
  logic                           map_wr_en;
  logic [WORD_AW-1:0]             map_wr_addr;
  bsa_pkg::map_word_t             map_wr_data;

  logic                           in_xfer;
  logic [WORD_AW-1:0]             next_w;
  logic [WORD_AW-1:0]             in_word;
  logic                           in_out_of_range;
  logic [bsa_pkg::BIT_SEL_W-1:0]  scan_bit;
  logic [bsa_pkg::BIT_SEL_W-1:0]  free_bit;
  logic                           heap_full;
  logic                           mul_en;
  logic [bsa_pkg::HANDLE_W-1:0]   cpu_sum;
  logic [bsa_pkg::HANDLE_W-1:0]   gpu_sum;

  bsa_map_mem #(
    .DEPTH (MAP_WORDS),
    .AW    (WORD_AW)
  ) u_map (
    .clk     (clk),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data)
  );

  bsa_handle_unit #(
    .IDX_W (IDX_W)
  ) u_handle (
    .clk     (clk),
    .en      (mul_en),
    .idx     (idx_r),
    .cfg     (cfg_r),
    .cpu_sum (cpu_sum),
    .gpu_sum (gpu_sum)
  );

  // Request decode helpers.
  assign in_ch.ready     = (state_r == S_IDLE);
  assign in_xfer         = in_ch.valid && in_ch.ready;
  assign next_w          = (cur_w_r == LAST_WORD) ? '0 : cur_w_r + 1'b1;
  assign in_word         = WORD_AW'(in_ch.slot_index >> bsa_pkg::BIT_SEL_W);
  assign in_out_of_range = 32'(in_ch.slot_index) >= 32'(MAPPED_SLOTS);
  assign scan_bit        = bsa_pkg::lowest_set(map_rd_data);
  assign free_bit        = idx_r[bsa_pkg::BIT_SEL_W-1:0];
  assign heap_full       = 32'(used_r) >= 32'(SLOT_COUNT);
  assign mul_en          = (state_r == S_MUL);
  assign out_load        = (state_r == S_RESULT) && (!out_valid_r || out_ch.ready);

  // Sequencer: clearing pass, bitmap scan, free check and read-modify-write.
  // Each request finishes its write-back before the next one reads the
  // bitmap, so no forwarding path is needed.
  always_comb begin
    state_nxt   = state_r;
    cur_w_nxt   = cur_w_r;
    scan_n_nxt  = scan_n_r;
    hint_nxt    = hint_r;
    used_nxt    = used_r;
    idx_nxt     = idx_r;
    status_nxt  = status_r;
    map_rd_en   = 1'b0;
    map_rd_addr = cur_w_r;
    map_wr_en   = 1'b0;
    map_wr_addr = cur_w_r;
    map_wr_data = map_rd_data;
    unique case (state_r)
      S_CLEAR: begin
        map_wr_en   = 1'b1;
        map_wr_data = '1;
        cur_w_nxt   = next_w;
        if (cur_w_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          idx_nxt    = IDX_W'(in_ch.slot_index);
          status_nxt = bsa_pkg::STATUS_OK;
          priority if (in_ch.kind == bsa_pkg::KIND_ALLOC) begin
            if (heap_full) begin
              status_nxt = bsa_pkg::STATUS_FULL;
              state_nxt  = S_MUL;
            end else begin
              map_rd_en   = 1'b1;
              map_rd_addr = hint_r;
              cur_w_nxt   = hint_r;
              scan_n_nxt  = '0;
              state_nxt   = S_SCAN;
            end
          end else if (in_ch.kind == bsa_pkg::KIND_FREE) begin
            if (in_out_of_range) begin
              status_nxt = bsa_pkg::STATUS_DBL_FREE;
              state_nxt  = S_MUL;
            end else begin
              map_rd_en   = 1'b1;
              map_rd_addr = in_word;
              cur_w_nxt   = in_word;
              state_nxt   = S_FREE;
            end
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_SCAN: begin
        priority if (map_rd_data != '0) begin
          // Take the lowest free bit of this word.
          map_wr_en   = 1'b1;
          map_wr_data = map_rd_data & ~(bsa_pkg::map_word_t'(1) << scan_bit);
          hint_nxt    = cur_w_r;
          used_nxt    = used_r + 1'b1;
          idx_nxt     = IDX_W'({cur_w_r, scan_bit});
          state_nxt   = S_MUL;
        end else if (scan_n_r == LAST_WORD) begin
          status_nxt = bsa_pkg::STATUS_FULL;
          state_nxt  = S_MUL;
        end else begin
          // Fetch the next word, wrapping past the last one.
          map_rd_en   = 1'b1;
          map_rd_addr = next_w;
          cur_w_nxt   = next_w;
          scan_n_nxt  = scan_n_r + 1'b1;
        end
      end
      S_FREE: begin
        if (map_rd_data[free_bit]) begin
          status_nxt = bsa_pkg::STATUS_DBL_FREE;
        end else begin
          map_wr_en   = 1'b1;
          map_wr_data = map_rd_data | (bsa_pkg::map_word_t'(1) << free_bit);
          hint_nxt    = cur_w_r;
          if (used_r != '0) begin
            used_nxt = used_r - 1'b1;
          end
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cur_w_r     <= '0;
      scan_n_r    <= '0;
      hint_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_w_r     <= cur_w_nxt;
      scan_n_r    <= scan_n_nxt;
      hint_r      <= hint_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request payload held while it is worked on.
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cpu_base       <= '0;
      cfg_r.gpu_base       <= '0;
      cfg_r.slot_stride    <= bsa_pkg::STRIDE_RESET;
      cfg_r.shader_visible <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsa_pkg::REG_CPU_BASE: cfg_r.cpu_base       <= cfg_data;
        bsa_pkg::REG_GPU_BASE: cfg_r.gpu_base       <= cfg_data;
        bsa_pkg::REG_STRIDE:   cfg_r.slot_stride    <= cfg_data[bsa_pkg::STRIDE_W-1:0];
        bsa_pkg::REG_VISIBLE:  cfg_r.shader_visible <= cfg_data[0];
      endcase
    end
  end

  // Result payload; a full heap reports zero handles and index.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_used_r   <= bsa_pkg::USED_OUT_W'(used_r);
      if (status_r == bsa_pkg::STATUS_FULL) begin
        out_index_r  <= '0;
        out_cpu_r    <= '0;
        out_gpu_r    <= '0;
        out_gvalid_r <= 1'b0;
      end else begin
        out_index_r  <= idx_r[bsa_pkg::SLOT_W-1:0];
        out_cpu_r    <= cpu_sum;
        out_gpu_r    <= cfg_r.shader_visible ? gpu_sum : '0;
        out_gvalid_r <= cfg_r.shader_visible;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_index = out_index_r;
  assign out_ch.cpu_handle   = out_cpu_r;
  assign out_ch.gpu_handle   = out_gpu_r;
  assign out_ch.gpu_valid    = out_gvalid_r;
  assign out_ch.used_count   = out_used_r;

  // The used count never exceeds the number of mapped slots.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= 32'(MAPPED_SLOTS))
    else $error("used slot count beyond mapped slots");

  // A successful allocation moves the hint to the word it took a bit from.
  a_alloc_hint: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && map_wr_en) |=> hint_r == $past(cur_w_r))
    else $error("hint not moved to allocated word");

  // A successful allocation raises the used count by exactly one.
  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && map_wr_en) |=> used_r == $past(used_r) + 1'b1)
    else $error("used count not incremented on allocation");

  // A new result only ever comes out of the result state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESULT)
    else $error("result raised outside the result state");

endmodule

`default_nettype wire

// ----- tb/sv/bitmap_slot_allocator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the bitmap slot allocator: a queue-fed driver, a
// checking monitor and a bit-exact prediction of the free bitmap and handles.
// Depends on bsa_pkg, bsa_if and the bitmap_slot_allocator RTL.

module bitmap_slot_allocator_tb;

  localparam int SLOT_COUNT = 1024;
  localparam int MAP_WORDS  = SLOT_COUNT / bsa_pkg::MAP_WORD_BITS;
  // Longest request (full scan of the map plus write-back), with some margin.
  localparam int SETTLE_CYCLES = 24;
  // Spare kind code; the block handles it like a lookup.
  localparam logic [bsa_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [bsa_pkg::KIND_W-1:0] kind;
    logic [bsa_pkg::SLOT_W-1:0] slot;
  } slot_request_t;

  typedef struct packed {
    logic [bsa_pkg::STATUS_W-1:0]   status;
    logic [bsa_pkg::SLOT_W-1:0]     index;
    logic [bsa_pkg::HANDLE_W-1:0]   cpu;
    logic [bsa_pkg::HANDLE_W-1:0]   gpu;
    logic                           gpu_ok;
    logic [bsa_pkg::USED_OUT_W-1:0] used;
  } slot_reply_t;

  logic clk;
  logic rst_n;
  logic                           cfg_we;
  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_data;

  bsa_in_if  req_ch ();
  bsa_out_if rsp_ch ();

  bitmap_slot_allocator #(.SLOT_COUNT(SLOT_COUNT)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the allocator: free bitmap, occupancy, search hint, registers.
  bsa_pkg::map_word_t             free_bits [MAP_WORDS];
  logic [bsa_pkg::USED_OUT_W-1:0] slots_in_use;
  logic [3:0]                     search_word;
  logic [bsa_pkg::HANDLE_W-1:0]   cpu_base_q;
  logic [bsa_pkg::HANDLE_W-1:0]   gpu_base_q;
  logic [bsa_pkg::STRIDE_W-1:0]   stride_q;
  logic                           visible_q;

  slot_request_t pending_requests [$];
  slot_reply_t   slot_replies_due [$];

  int src_idle_pct;
  int snk_idle_pct;
  int error_count;
  int accepted_count;
  int checked_count;
  int full_count;
  int double_free_count;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous run limit.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Fill in the handle fields of a reply for a given slot.
  function automatic slot_reply_t with_handles(input slot_reply_t r,
                                               input logic [bsa_pkg::SLOT_W-1:0] idx);
    logic [bsa_pkg::HANDLE_W-1:0] offset;
    offset = bsa_pkg::HANDLE_W'(idx) * bsa_pkg::HANDLE_W'(stride_q);
    r.index  = idx;
    r.cpu    = cpu_base_q + offset;
    r.gpu    = visible_q ? gpu_base_q + offset : '0;
    r.gpu_ok = visible_q;
    return r;
  endfunction

  // Apply one accepted request to the shadow state and queue its reply.
  task automatic apply_request(input slot_request_t req);
    slot_reply_t r;
    logic [3:0]  w;
    logic [5:0]  b;
    logic        found;
    r = '0;
    r.status = bsa_pkg::STATUS_OK;
    if (req.kind == bsa_pkg::KIND_ALLOC) begin
      found = 1'b0;
      w = search_word;
      if (slots_in_use < bsa_pkg::USED_OUT_W'(SLOT_COUNT)) begin
        for (int n = 0; n < MAP_WORDS; n++) begin
          if (!found) begin
            if (free_bits[w] != '0) begin
              // Lowest free bit of this word.
              for (int i = bsa_pkg::MAP_WORD_BITS - 1; i >= 0; i--) begin
                if (free_bits[w][i]) begin
                  b = 6'(i);
                end
              end
              free_bits[w][b] = 1'b0;
              search_word = w;
              slots_in_use++;
              found = 1'b1;
              r = with_handles(r, {w, b});
            end else begin
              w = w + 4'd1;
            end
          end
        end
      end
      if (!found) begin
        r.status = bsa_pkg::STATUS_FULL;
        full_count++;
      end
    end else if (req.kind == bsa_pkg::KIND_FREE) begin
      r = with_handles(r, req.slot);
      w = req.slot[9:6];
      b = req.slot[5:0];
      if (free_bits[w][b]) begin
        r.status = bsa_pkg::STATUS_DBL_FREE;
        double_free_count++;
      end else begin
        free_bits[w][b] = 1'b1;
        search_word = w;
        if (slots_in_use != '0) begin
          slots_in_use--;
        end
      end
    end else begin
      r = with_handles(r, req.slot);
    end
    r.used = slots_in_use;
    slot_replies_due.push_back(r);
  endtask

  // Request driver: a request stays on the channel until its transfer.
  always @(posedge clk) begin
    slot_request_t nxt;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        apply_request('{kind: req_ch.kind, slot: req_ch.slot_index});
        accepted_count++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = pending_requests.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.kind       <= nxt.kind;
          req_ch.slot_index <= nxt.slot;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor: checks each transfer against the oldest prediction.
  always @(posedge clk) begin
    slot_reply_t want;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (slot_replies_due.size() == 0) begin
          report_mismatch("unexpected reply, status", 64'(rsp_ch.status), 64'd0);
        end else begin
          want = slot_replies_due.pop_front();
          checked_count++;
          if (rsp_ch.status !== want.status)
            report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
          if (rsp_ch.result_index !== want.index)
            report_mismatch("result_index", 64'(rsp_ch.result_index), 64'(want.index));
          if (rsp_ch.cpu_handle !== want.cpu)
            report_mismatch("cpu_handle", rsp_ch.cpu_handle, want.cpu);
          if (rsp_ch.gpu_handle !== want.gpu)
            report_mismatch("gpu_handle", rsp_ch.gpu_handle, want.gpu);
          if (rsp_ch.gpu_valid !== want.gpu_ok)
            report_mismatch("gpu_valid", 64'(rsp_ch.gpu_valid), 64'(want.gpu_ok));
          if (rsp_ch.used_count !== want.used)
            report_mismatch("used_count", 64'(rsp_ch.used_count), 64'(want.used));
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic push_request(input logic [bsa_pkg::KIND_W-1:0] kind,
                              input logic [bsa_pkg::SLOT_W-1:0] slot);
    pending_requests.push_back('{kind: kind, slot: slot});
  endtask

  // Wait until the block has drained every request and reply.
  task automatic wait_idle();
    while (pending_requests.size() > 0 || req_ch.valid || slot_replies_due.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all four registers on consecutive edges, keeping the shadow in step.
  task automatic set_config(input logic [bsa_pkg::HANDLE_W-1:0] cpu,
                            input logic [bsa_pkg::HANDLE_W-1:0] gpu,
                            input logic [bsa_pkg::STRIDE_W-1:0] stride, input logic vis);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= bsa_pkg::REG_CPU_BASE; cfg_data <= cpu;
    @(posedge clk);
    cfg_index <= bsa_pkg::REG_GPU_BASE; cfg_data <= gpu;
    @(posedge clk);
    cfg_index <= bsa_pkg::REG_STRIDE; cfg_data <= bsa_pkg::CFG_DATA_W'(stride);
    @(posedge clk);
    cfg_index <= bsa_pkg::REG_VISIBLE; cfg_data <= bsa_pkg::CFG_DATA_W'(vis);
    @(posedge clk);
    cfg_we <= 1'b0;
    cpu_base_q = cpu;
    gpu_base_q = gpu;
    stride_q   = stride;
    visible_q  = vis;
  endtask

  // A slot that the shadow map holds as taken, searched from a random point.
  function automatic logic [bsa_pkg::SLOT_W-1:0] pick_taken_slot();
    logic [3:0] w;
    logic [5:0] b;
    w = 4'($urandom_range(MAP_WORDS - 1));
    for (int n = 0; n < MAP_WORDS; n++) begin
      if (free_bits[w] != '1) begin
        b = 6'($urandom_range(bsa_pkg::MAP_WORD_BITS - 1));
        for (int i = 0; i < bsa_pkg::MAP_WORD_BITS; i++) begin
          if (!free_bits[w][b]) return {w, b};
          b = b + 6'd1;
        end
      end
      w = w + 4'd1;
    end
    return bsa_pkg::SLOT_W'($urandom_range(SLOT_COUNT - 1));
  endfunction

  // Queue one random request once the driver is nearly out of work.
  task automatic add_random_request(input int alloc_pct, input int free_pct);
    int roll;
    logic [bsa_pkg::SLOT_W-1:0] slot;
    while (pending_requests.size() >= 4) @(negedge clk);
    roll = $urandom_range(99);
    slot = bsa_pkg::SLOT_W'($urandom_range(SLOT_COUNT - 1));
    if (roll < alloc_pct) begin
      push_request(bsa_pkg::KIND_ALLOC, slot);
    end else if (roll < alloc_pct + free_pct) begin
      // Mostly frees of taken slots; the rest use a random slot.
      if ($urandom_range(99) < 85) slot = pick_taken_slot();
      push_request(bsa_pkg::KIND_FREE, slot);
    end else begin
      push_request($urandom_range(1) ? bsa_pkg::KIND_LOOKUP : KIND_SPARE, slot);
    end
  endtask

  // Main sequence: reset, directed requests, then three random phases.
  initial begin
    int guard;
    req_ch.valid = 1'b0;
    req_ch.kind = bsa_pkg::KIND_ALLOC;
    req_ch.slot_index = '0;
    rsp_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = bsa_pkg::REG_CPU_BASE;
    cfg_data = '0;
    rst_n = 1'b0;
    for (int i = 0; i < MAP_WORDS; i++) free_bits[i] = '1;
    slots_in_use = '0;
    search_word = '0;
    cpu_base_q = '0;
    gpu_base_q = '0;
    stride_q = bsa_pkg::STRIDE_RESET;
    visible_q = 1'b0;
    error_count = 0;
    accepted_count = 0;
    checked_count = 0;
    full_count = 0;
    double_free_count = 0;
    src_idle_pct = 29;
    snk_idle_pct = 55;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset register values.
    push_request(bsa_pkg::KIND_ALLOC, 10'd0);
    push_request(bsa_pkg::KIND_ALLOC, 10'h3FF);
    push_request(bsa_pkg::KIND_ALLOC, 10'h155);
    push_request(bsa_pkg::KIND_LOOKUP, 10'd0);
    push_request(bsa_pkg::KIND_LOOKUP, 10'h3FF);   // lookup of a slot that is free
    push_request(KIND_SPARE, 10'd1);               // spare kind acts as a lookup
    push_request(bsa_pkg::KIND_FREE, 10'd1);
    push_request(bsa_pkg::KIND_FREE, 10'd1);       // second free of the same slot
    push_request(bsa_pkg::KIND_FREE, 10'h3FF);     // free of a slot never taken
    push_request(bsa_pkg::KIND_ALLOC, 10'd0);
    push_request(bsa_pkg::KIND_FREE, 10'd0);
    push_request(bsa_pkg::KIND_ALLOC, 10'h2AA);
    push_request(bsa_pkg::KIND_LOOKUP, 10'h2AA);
    push_request(KIND_SPARE, 10'h155);
    push_request(bsa_pkg::KIND_FREE, 10'd512);     // already free, hint must stay
    push_request(bsa_pkg::KIND_ALLOC, 10'd0);
    wait_idle();

    // Random mix with random bases and stride, GPU handles visible.
    set_config({$urandom, $urandom}, {$urandom, $urandom},
               bsa_pkg::STRIDE_W'($urandom_range(1, 65535)), 1'b1);
    for (int i = 0; i < 60; i++) add_random_request(50, 35);
    wait_idle();

    // Fill the heap at the extreme register values, then work around full.
    src_idle_pct = 55;
    snk_idle_pct = 29;
    set_config('1, '1, '1, 1'b1);
    guard = 0;
    while (slots_in_use < bsa_pkg::USED_OUT_W'(SLOT_COUNT) && guard < 2000) begin
      add_random_request(97, 2);
      guard++;
    end
    for (int i = 0; i < 40; i++) add_random_request(50, 30);
    wait_idle();

    // Mostly frees, zero CPU base, unit stride, GPU handles hidden.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_config('0, {$urandom, $urandom}, 16'd1, 1'b0);
    for (int i = 0; i < 80; i++) add_random_request(25, 60);

    // Drain and settle.
    while (pending_requests.size() > 0 || req_ch.valid) @(negedge clk);
    guard = 0;
    while (slot_replies_due.size() > 0 && guard < 4000) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (slot_replies_due.size() > 0)
      report_mismatch("replies never delivered", 64'(slot_replies_due.size()), 64'd0);

    $display("Covered %0d requests, %0d replies checked, %0d heap-full and %0d double-free cases.",
             accepted_count, checked_count, full_count, double_free_count);
    $display("Four register settings were used, from reset values to all-ones bases.");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- bitmap_slot_allocator.f -----
src/bsa_pkg.sv
src/bsa_if.sv
src/bsa_map_mem.sv
src/bsa_handle_unit.sv
src/bitmap_slot_allocator.sv
tb/sv/bitmap_slot_allocator_tb.sv
